[hdl/bed_pkg.sv]
package bed_pkg;

  localparam int MAX_EVENTS  = 3;
  localparam int DUR_W       = 32;
  localparam int NOW_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_DATA_W   = 40;
  localparam int CNT_W       = 2;

  typedef enum logic [2:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_SINGLE   = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_LONG     = 3'd4,
    EV_HOLD     = 3'd5,
    EV_REPEAT   = 3'd6
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY     = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_LONG_PRESS   = 3'd2,
    CFG_REPEAT       = 3'd3,
    CFG_DOUBLE_ON    = 3'd4,
    CFG_DOUBLE_CLICK = 3'd5,
    CFG_KEY_ON       = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic                  polarity_active_low;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] long_press_ms;
    logic [CFG_DATA_W-1:0] repeat_ms;
    logic                  double_click_on;
    logic [CFG_DATA_W-1:0] double_click_ms;
    logic                  key_on;
  } cfg_t;

  // Events caused by one scan, in delivery order; count is never zero in the queue.
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    event_kind_t [MAX_EVENTS-1:0]      kind;
    logic [MAX_EVENTS-1:0][DUR_W-1:0]  dur;
  } bundle_t;

endpackage

[hdl/bed_front.sv]
module bed_front
  import bed_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         scan_valid,
  output logic         scan_ready,
  input  logic         pin_level,
  input  logic [NOW_W-1:0] now_ms,
  output logic         push,
  output bundle_t      push_data,
  input  logic         q_full
);

  logic                 raw_previous;
  logic                 debounced;
  logic                 held;
  logic                 awaiting_second;
  logic [1:0]           clicks_pending;
  logic [TIME_BITS-1:0] change_stamp;
  logic [TIME_BITS-1:0] press_stamp;
  logic [TIME_BITS-1:0] repeat_stamp;
  logic [TIME_BITS-1:0] click_stamp;

  logic                 raw_previous_next;
  logic                 debounced_next;
  logic                 held_next;
  logic                 awaiting_second_next;
  logic [1:0]           clicks_pending_next;
  logic [TIME_BITS-1:0] change_stamp_next;
  logic [TIME_BITS-1:0] press_stamp_next;
  logic [TIME_BITS-1:0] repeat_stamp_next;
  logic [TIME_BITS-1:0] click_stamp_next;

  logic                 accept;
  logic [TIME_BITS-1:0] now_t;
  logic                 pressed;
  logic                 changed;
  logic [TIME_BITS-1:0] el_change;
  logic [TIME_BITS-1:0] el_press;
  logic [TIME_BITS-1:0] el_click;
  logic [TIME_BITS-1:0] el_repeat;
  logic                 edge_seen;
  logic                 press_edge;
  logic                 release_edge;
  logic                 is_long;
  logic [1:0]           pend_inc;
  logic                 short_click;
  logic [1:0]           pend_mid;
  logic                 await_mid;
  logic                 timeout;
  logic                 repeat_due;
  logic [DUR_W-1:0]     rel_dur;
  logic [DUR_W-1:0]     hold_dur;
  logic [6:0]           cand_valid;
  event_kind_t [6:0]    cand_kind;
  logic [6:0][DUR_W-1:0] cand_dur;
  bundle_t              bundle;

  assign accept     = scan_valid && scan_ready;
  assign scan_ready = !q_full;
  assign now_t      = TIME_BITS'(now_ms);
  assign pressed    = cfg.polarity_active_low ? !pin_level : pin_level;
  assign changed    = pressed != raw_previous;

  assign el_change = changed ? '0 : now_t - change_stamp;
  assign el_press  = now_t - press_stamp;
  assign el_click  = now_t - click_stamp;
  assign el_repeat = now_t - repeat_stamp;

  assign edge_seen    = (el_change >= TIME_BITS'(cfg.debounce_ms)) && (pressed != debounced);
  assign press_edge   = edge_seen && pressed;
  assign release_edge = edge_seen && !pressed;
  assign is_long      = el_press >= TIME_BITS'(cfg.long_press_ms);
  assign short_click  = release_edge && !is_long;
  assign pend_inc     = clicks_pending + 2'd1;
  assign rel_dur      = DUR_W'(el_press);
  assign hold_dur     = press_edge ? '0 : DUR_W'(el_press);

  always_comb begin
    pend_mid  = clicks_pending;
    await_mid = awaiting_second;
    if (release_edge) begin
      if (is_long) begin
        pend_mid  = 2'd0;
        await_mid = 1'b0;
      end else if (cfg.double_click_on) begin
        if (pend_inc >= 2'd2) begin
          pend_mid  = 2'd0;
          await_mid = 1'b0;
        end else begin
          pend_mid  = pend_inc;
          await_mid = 1'b1;
        end
      end
    end
  end

  // A click stamped on this scan has zero elapsed time and cannot time out.
  assign timeout = cfg.double_click_on && await_mid && !short_click &&
                   (el_click > TIME_BITS'(cfg.double_click_ms));
  assign held_next  = edge_seen ? pressed : held;
  assign repeat_due = held_next && (cfg.repeat_ms != '0) && !press_edge &&
                      (el_repeat >= TIME_BITS'(cfg.repeat_ms));

  always_comb begin
    cand_valid = '0;
    cand_kind  = '{default: EV_PRESSED};
    cand_dur   = '0;
    if (press_edge) begin
      cand_valid[0] = 1'b1;
      cand_kind[0]  = EV_PRESSED;
    end else if (release_edge) begin
      cand_dur[0] = rel_dur;
      if (is_long) begin
        cand_valid[0] = 1'b1;
        cand_kind[0]  = EV_LONG;
      end else if (!cfg.double_click_on) begin
        cand_valid[0] = 1'b1;
        cand_kind[0]  = EV_SINGLE;
      end else if (pend_inc >= 2'd2) begin
        cand_valid[0] = 1'b1;
        cand_kind[0]  = EV_DOUBLE;
      end
    end
    cand_valid[1] = release_edge;
    cand_kind[1]  = EV_RELEASED;
    cand_dur[1]   = rel_dur;
    cand_valid[2] = timeout && (pend_mid > 2'd0);
    cand_kind[2]  = EV_SINGLE;
    cand_valid[3] = timeout && (pend_mid > 2'd1);
    cand_kind[3]  = EV_SINGLE;
    cand_valid[4] = timeout && (pend_mid > 2'd2);
    cand_kind[4]  = EV_SINGLE;
    cand_valid[5] = held_next;
    cand_kind[5]  = EV_HOLD;
    cand_dur[5]   = hold_dur;
    cand_valid[6] = repeat_due;
    cand_kind[6]  = EV_REPEAT;
    cand_dur[6]   = hold_dur;
  end

  // Packs the candidates in order into at most three slots; extra ones are dropped.
  always_comb begin
    bundle = '0;
    for (int i = 0; i < 7; i++) begin
      if (cand_valid[i] && (bundle.count < CNT_W'(MAX_EVENTS))) begin
        bundle.kind[bundle.count] = cand_kind[i];
        bundle.dur[bundle.count]  = cand_dur[i];
        bundle.count              = bundle.count + CNT_W'(1);
      end
    end
  end

  assign push      = accept && cfg.key_on && (bundle.count != '0);
  assign push_data = bundle;

  always_comb begin
    raw_previous_next    = pressed;
    change_stamp_next    = changed ? now_t : change_stamp;
    debounced_next       = edge_seen ? pressed : debounced;
    press_stamp_next     = press_edge ? now_t : press_stamp;
    repeat_stamp_next    = (press_edge || repeat_due) ? now_t : repeat_stamp;
    click_stamp_next     = short_click ? now_t : click_stamp;
    clicks_pending_next  = timeout ? 2'd0 : pend_mid;
    awaiting_second_next = timeout ? 1'b0 : await_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous    <= 1'b0;
      debounced       <= 1'b0;
      held            <= 1'b0;
      awaiting_second <= 1'b0;
      clicks_pending  <= 2'd0;
      change_stamp    <= '0;
      press_stamp     <= '0;
      repeat_stamp    <= '0;
      click_stamp     <= '0;
    end else if (accept && cfg.key_on) begin
      raw_previous    <= raw_previous_next;
      debounced       <= debounced_next;
      held            <= held_next;
      awaiting_second <= awaiting_second_next;
      clicks_pending  <= clicks_pending_next;
      change_stamp    <= change_stamp_next;
      press_stamp     <= press_stamp_next;
      repeat_stamp    <= repeat_stamp_next;
      click_stamp     <= click_stamp_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg.key_on) |=> $stable(debounced) && $stable(clicks_pending))
    else $error("Scan changed state while the key was off.");

  assert property (@(posedge clk) disable iff (rst)
    held == debounced)
    else $error("Held flag disagrees with the debounced level.");

endmodule

[hdl/bed_queue.sv]
module bed_queue
  import bed_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output bundle_t q_data
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full    = count == COUNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Push into a full queue.");

  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("Pop from an empty queue.");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + COUNT_W'(1))
    else $error("Queue count did not follow a push.");

endmodule

[hdl/bed_back.sv]
module bed_back
  import bed_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bundle_t          q_data,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DUR_W-1:0] m_axis_tdata,
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  logic [CNT_W-1:0] idx;
  logic             advance;
  logic             take;
  logic             last_ev;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign take    = advance && q_valid;
  assign last_ev = idx == (q_data.count - CNT_W'(1));
  assign pop     = take && last_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= q_valid;
      end
      if (take) begin
        idx <= last_ev ? '0 : idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= q_data.dur[idx];
      m_axis_tuser <= q_data.kind[idx];
      m_axis_tlast <= last_ev;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_data.count != '0) && (idx < q_data.count))
    else $error("Event index outside the queued bundle.");

  assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> idx == '0)
    else $error("Event index left mid-bundle with an empty queue.");

endmodule

[hdl/button_event_detector.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: pin_level [0], now_ms [32:1], zero fill [39:33]
// m_axis    out        tdata: duration_ms [31:0]; tuser: event_kind; tlast: last_of_scan
// cfg       in         cfg_index: register number; cfg_data: value (low bits used)
//
// A scan request is classified in the cycle it is accepted and its events enter a
// two-entry queue; the first event then passes the queue and the output register
// before it is valid on m_axis. The output side sends one event per cycle while
// m_axis_tready is high; a scan yields 0 to 3 events, and scans are accepted every
// cycle while the queue has room. Reset is synchronous and restores every control
// and state register. A stalled output fills the queue, then s_axis_tready drops.
module button_event_detector
  import bed_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin_level, now_ms
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DUR_W-1:0]      m_axis_tdata,   // duration_ms
  output logic [2:0]            m_axis_tuser,   // event_kind
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    push;
  bundle_t push_data;
  logic    q_full;
  logic    q_valid;
  bundle_t q_data;
  logic    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polarity_active_low <= 1'b1;
      cfg.debounce_ms         <= CFG_DATA_W'(20);
      cfg.long_press_ms       <= CFG_DATA_W'(1000);
      cfg.repeat_ms           <= '0;
      cfg.double_click_on     <= 1'b0;
      cfg.double_click_ms     <= CFG_DATA_W'(300);
      cfg.key_on              <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLARITY:     cfg.polarity_active_low <= cfg_data[0];
        CFG_DEBOUNCE:     cfg.debounce_ms         <= cfg_data;
        CFG_LONG_PRESS:   cfg.long_press_ms       <= cfg_data;
        CFG_REPEAT:       cfg.repeat_ms           <= cfg_data;
        CFG_DOUBLE_ON:    cfg.double_click_on     <= cfg_data[0];
        CFG_DOUBLE_CLICK: cfg.double_click_ms     <= cfg_data;
        CFG_KEY_ON:       cfg.key_on              <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bed_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .scan_valid (s_axis_tvalid),
    .scan_ready (s_axis_tready),
    .pin_level  (s_axis_tdata[0]),
    .now_ms     (s_axis_tdata[NOW_W:1]),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  bed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  bed_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[tb/button_event_checker.sv]
`timescale 1ns / 1ps

module button_event_checker
  import bed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pin_level, now_ms
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [DUR_W-1:0]      m_axis_tdata,   // duration_ms
  input  logic [2:0]            m_axis_tuser,   // event_kind
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    event_kind_t      kind;
    logic [DUR_W-1:0] dur;
    logic             last;
  } button_event_t;

  button_event_t expected_events[$];
  button_event_t scan_events[MAX_EVENTS];
  int scan_count;

  cfg_t regs;
  logic raw_prev;
  logic debounced;
  logic held;
  logic awaiting_second;
  logic [NOW_W-1:0] change_t;
  logic [NOW_W-1:0] press_t;
  logic [NOW_W-1:0] repeat_t;
  logic [NOW_W-1:0] click_t;
  logic [1:0] clicks_pending;

  function void add_event(input event_kind_t ev_kind, input logic [DUR_W-1:0] ev_dur);
    if (scan_count < MAX_EVENTS) begin
      scan_events[scan_count] = '{kind: ev_kind, dur: ev_dur, last: 1'b0};
      scan_count++;
    end
  endfunction

  function void predict_scan(input logic level, input logic [NOW_W-1:0] now);
    logic pressed;
    logic [NOW_W-1:0] dur;
    logic [NOW_W-1:0] since;
    int i;
    scan_count = 0;
    if (regs.key_on) begin
      pressed = regs.polarity_active_low ? !level : level;
      if (pressed != raw_prev) begin
        change_t = now;
        raw_prev = pressed;
      end
      since = now - change_t;
      if (since >= NOW_W'(regs.debounce_ms) && pressed != debounced) begin
        debounced = pressed;
        if (pressed) begin
          press_t = now;
          held = 1'b1;
          repeat_t = now;
          add_event(EV_PRESSED, '0);
        end else begin
          dur = now - press_t;
          held = 1'b0;
          if (dur < NOW_W'(regs.long_press_ms)) begin
            click_t = now;
            if (regs.double_click_on) begin
              clicks_pending = clicks_pending + 2'd1;
              awaiting_second = 1'b1;
              if (clicks_pending >= 2'd2) begin
                add_event(EV_DOUBLE, dur);
                clicks_pending = '0;
                awaiting_second = 1'b0;
              end
            end else begin
              add_event(EV_SINGLE, dur);
            end
          end else begin
            add_event(EV_LONG, dur);
            clicks_pending = '0;
            awaiting_second = 1'b0;
          end
          add_event(EV_RELEASED, dur);
        end
      end
      since = now - click_t;
      if (regs.double_click_on && awaiting_second && since > NOW_W'(regs.double_click_ms)) begin
        for (i = 0; i < int'(clicks_pending); i++) add_event(EV_SINGLE, '0);
        clicks_pending = '0;
        awaiting_second = 1'b0;
      end
      if (held) begin
        dur = now - press_t;
        add_event(EV_HOLD, dur);
        since = now - repeat_t;
        if (regs.repeat_ms != 0 && since >= NOW_W'(regs.repeat_ms)) begin
          add_event(EV_REPEAT, dur);
          repeat_t = now;
        end
      end
    end
    for (i = 0; i < scan_count; i++) begin
      if (i == scan_count - 1) scan_events[i].last = 1'b1;
      expected_events.push_back(scan_events[i]);
    end
  endfunction

  always @(posedge clk) begin
    button_event_t want;
    if (rst) begin
      regs.polarity_active_low = 1'b1;
      regs.debounce_ms = 16'd20;
      regs.long_press_ms = 16'd1000;
      regs.repeat_ms = 16'd0;
      regs.double_click_on = 1'b0;
      regs.double_click_ms = 16'd300;
      regs.key_on = 1'b1;
      raw_prev = 1'b0;
      debounced = 1'b0;
      held = 1'b0;
      awaiting_second = 1'b0;
      change_t = '0;
      press_t = '0;
      repeat_t = '0;
      click_t = '0;
      clicks_pending = '0;
      expected_events.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event kind %0d duration %0d last %0b", $time,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (want.kind != event_kind_t'(m_axis_tuser) || want.dur != m_axis_tdata ||
              want.last != m_axis_tlast) begin
            $display({"%0t: expected kind %0d duration %0d last %0b, ",
                      "got kind %0d duration %0d last %0b"},
                     $time, want.kind, want.dur, want.last, m_axis_tuser, m_axis_tdata,
                     m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLARITY:     regs.polarity_active_low = cfg_data[0];
          CFG_DEBOUNCE:     regs.debounce_ms = cfg_data;
          CFG_LONG_PRESS:   regs.long_press_ms = cfg_data;
          CFG_REPEAT:       regs.repeat_ms = cfg_data;
          CFG_DOUBLE_ON:    regs.double_click_on = cfg_data[0];
          CFG_DOUBLE_CLICK: regs.double_click_ms = cfg_data;
          CFG_KEY_ON:       regs.key_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_scan(s_axis_tdata[0], s_axis_tdata[NOW_W:1]);
      end
    end
    outstanding = expected_events.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bed_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SCAN_TARGET  = 105;
  localparam int HOLD_OFF_LEN = 300;

  localparam int RX_STEADY = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_SLOW   = 2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DUR_W-1:0]      m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int scans_sent = 0;
  int hold_off_req = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;
  int rx_mode = RX_STEADY;
  int rx_mode_left = 0;
  cfg_t settings;
  logic [NOW_W-1:0] clock_ms = '0;

  always #5 clk = ~clk;

  button_event_detector uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  button_event_checker event_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // A hold-off request stalls the event side for a long stretch, so the queue fills up.
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_LEN;
      m_axis_tready <= 1'b0;
    end else if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(RX_STEADY, RX_SLOW);
      rx_mode_left <= $urandom_range(10, 60);
      m_axis_tready <= 1'b1;
    end else begin
      rx_mode_left <= rx_mode_left - 1;
      case (rx_mode)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
        default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(input logic pol, input int deb, input int long_ms,
                                    input int rep, input logic dbl, input int dbl_ms,
                                    input logic key);
    cfg_t c;
    c.polarity_active_low = pol;
    c.debounce_ms = CFG_DATA_W'(deb);
    c.long_press_ms = CFG_DATA_W'(long_ms);
    c.repeat_ms = CFG_DATA_W'(rep);
    c.double_click_on = dbl;
    c.double_click_ms = CFG_DATA_W'(dbl_ms);
    c.key_on = key;
    return c;
  endfunction

  function automatic int pick_ms(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    return make_cfg(1'($urandom_range(0, 1)), pick_ms(1, 40), pick_ms(20, 400),
                    pick_ms(5, 60), 1'($urandom_range(0, 1)), pick_ms(20, 200),
                    $urandom_range(0, 7) != 0);
  endfunction

  function automatic logic level_for(input logic down);
    return down ^ settings.polarity_active_low;
  endfunction

  task automatic send_scan(input logic lvl, input logic [NOW_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W-NOW_W-1){1'b0}}, stamp, lvl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    scans_sent++;
  endtask

  task automatic scan_after(input logic lvl, input int unsigned dt);
    clock_ms = clock_ms + dt;
    send_scan(lvl, clock_ms);
  endtask

  // Stop sending and wait until every predicted event has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    settle();
    write_reg(CFG_POLARITY, CFG_DATA_W'(c.polarity_active_low));
    write_reg(CFG_DEBOUNCE, c.debounce_ms);
    write_reg(CFG_LONG_PRESS, c.long_press_ms);
    write_reg(CFG_REPEAT, c.repeat_ms);
    write_reg(CFG_DOUBLE_ON, CFG_DATA_W'(c.double_click_on));
    write_reg(CFG_DOUBLE_CLICK, c.double_click_ms);
    write_reg(CFG_KEY_ON, CFG_DATA_W'(c.key_on));
    cfg_valid <= 1'b0;
    settings = c;
  endtask

  // One press and release, with optional contact bounce on the press edge.
  task automatic press_release(input int unsigned hold_ms, input int hold_scans,
                               input int bounces);
    int unsigned settle_ms;
    int k;
    settle_ms = 32'(settings.debounce_ms);
    for (k = 0; k < bounces; k++) scan_after(level_for(k % 2 == 0), $urandom_range(1, 3));
    scan_after(level_for(1'b1), $urandom_range(1, 3));
    scan_after(level_for(1'b1), settle_ms + $urandom_range(1, 3));
    for (k = 0; k < hold_scans; k++) scan_after(level_for(1'b1), hold_ms / (hold_scans + 1));
    scan_after(level_for(1'b0), hold_ms / (hold_scans + 1));
    scan_after(level_for(1'b0), settle_ms + $urandom_range(1, 3));
  endtask

  initial begin
    int gestures;
    int g;
    settings = make_cfg(1'b1, 20, 1000, 0, 1'b0, 300, 1'b1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a bouncing short click, then a long press across the time wrap.
    press_release(100, 0, 1);
    clock_ms = 32'hFFFF_FC00;
    press_release(1500, 0, 0);

    // Double click mode with zero debounce: a pending click that times out when the
    // next press arrives, then a double click.
    apply_settings(make_cfg(1'b0, 0, 65535, 1, 1'b1, 50, 1'b1));
    press_release(10, 0, 0);
    clock_ms = clock_ms + 100;
    press_release(10, 0, 0);
    press_release(10, 0, 0);

    // A pending click survives while double click mode is off.
    press_release(10, 0, 0);
    apply_settings(make_cfg(1'b0, 0, 65535, 1, 1'b0, 50, 1'b1));
    scan_after(level_for(1'b0), 500);
    apply_settings(make_cfg(1'b0, 0, 65535, 1, 1'b1, 50, 1'b1));
    scan_after(level_for(1'b0), 1);

    // Key disabled: scans change nothing.
    apply_settings(make_cfg(1'b0, 0, 65535, 1, 1'b1, 50, 1'b0));
    scan_after(level_for(1'b1), 5);
    scan_after(level_for(1'b1), 5);

    // Long output stall while a held button keeps producing events.
    apply_settings(make_cfg(1'b1, 5, 1000, 10, 1'b0, 300, 1'b1));
    hold_off_req <= hold_off_req + 1;
    press_release(400, 10, 0);
    settle();

    while (scans_sent < SCAN_TARGET) begin
      apply_settings(random_cfg());
      clock_ms = $urandom();
      gestures = $urandom_range(3, 6);
      for (g = 0; g < gestures && scans_sent < SCAN_TARGET; g++) begin
        case ($urandom_range(0, 7))
          6: scan_after(1'($urandom_range(0, 1)),
                        $urandom_range(0, 3 * int'(settings.debounce_ms) + 5));
          7: scan_after(level_for(1'b0),
                        $urandom_range(0, int'(settings.double_click_ms) + 100));
          default: press_release($urandom_range(0, 2 * int'(settings.long_press_ms) + 50),
                                 $urandom_range(0, 3), $urandom_range(0, 2));
        endcase
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
